FILE: src/lfd_pkg.sv
// Shared types and constants for the log frame deserializer.
`timescale 1ns / 1ps

package lfd_pkg;

  // Frame layout limits
  localparam int NUM_FRAMES   = 3;
  localparam int MAX_VARS     = 24;

  // Field widths
  localparam int BYTE_W       = 8;
  localparam int COUNT_W      = 5;
  localparam int SIZES_W      = 48;
  localparam int WORD_W       = 32;
  localparam int POS_W        = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;

  // Register map: index bit 0 picks count or sizes, upper bits pick the frame
  localparam int CFG_REGS     = 2 * NUM_FRAMES;
  localparam logic REG_KIND_COUNT = 1'b0;
  localparam logic REG_KIND_SIZES = 1'b1;

  localparam logic [BYTE_W-1:0] START_MARK = 8'hFF;
  localparam logic [POS_W-1:0]  TIME_LAST_POS = 2'd3;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_ID,
    PH_TIME,
    PH_VARS
  } phase_t;

  // Layout of the frame being parsed
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SIZES_W-1:0] sizes;
  } frame_info_t;

  // One result from the parser
  typedef struct packed {
    logic               emit;
    logic               kind;
    logic [BYTE_W-1:0]  frame_number;
    logic [WORD_W-1:0]  frame_time;
    logic [COUNT_W-1:0] var_index;
    logic [WORD_W-1:0]  var_value;
    logic               frame_last;
  } result_t;

endpackage

FILE: src/log_frame_deserializer.sv
// Top level of the log frame deserializer.
//
// Input channel: in_valid/in_ready carry one received byte (rx_data) with the
// logging_active flag. Each transfer advances the frame parser by one byte:
// start marker 0xFF, frame id, 4-byte timestamp, then the frame's variables
// as laid out in the frame count and sizes registers.
// Output channel: out_valid/out_ready carry one result per completed variable
// or per frame without variables, with frame_last marking the frame's end.
// A result is loaded into the output register by the transfer of the byte
// that completes it. Throughput: one byte per cycle while in_ready is high;
// the parser's next state is combinational and a single output register holds
// the result. in_ready is high while that register is empty or being emptied
// in the same cycle, so a stalled receiver holds off input only once a result waits.
// Configuration: cfg_we writes cfg_data to register cfg_index (count and
// sizes for each frame in turn); write only while the block is idle.
// Reset (rst, synchronous): parser waits for a start marker, all layout
// registers read zero and the output register is empty.
`timescale 1ns / 1ps

module log_frame_deserializer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [lfd_pkg::BYTE_W-1:0]         rx_data,
  input  logic                               logging_active,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               kind,
  output logic [lfd_pkg::BYTE_W-1:0]         frame_number,
  output logic [lfd_pkg::WORD_W-1:0]         frame_time,
  output logic [lfd_pkg::COUNT_W-1:0]        var_index,
  output logic [lfd_pkg::WORD_W-1:0]         var_value,
  output logic                               frame_last
);

  lfd_pkg::frame_info_t         frame_info;
  lfd_pkg::result_t             result;
  logic [lfd_pkg::BYTE_W-1:0]   lookup_frame;
  logic                         step;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  lfd_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .lookup_frame (lookup_frame),
    .frame_info   (frame_info)
  );

  lfd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .rx_data        (rx_data),
    .logging_active (logging_active),
    .frame_info     (frame_info),
    .lookup_frame   (lookup_frame),
    .result         (result)
  );

  // Output register: loads on a transfer that completes a result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= result.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.emit) begin
      kind         <= result.kind;
      frame_number <= result.frame_number;
      frame_time   <= result.frame_time;
      var_index    <= result.var_index;
      var_value    <= result.var_value;
      frame_last   <= result.frame_last;
    end
  end

endmodule

FILE: src/lfd_cfg_regs.sv
// Frame layout registers and per-frame layout lookup.
`timescale 1ns / 1ps

module lfd_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [lfd_pkg::BYTE_W-1:0]         lookup_frame,
  output lfd_pkg::frame_info_t               frame_info
);

  logic [lfd_pkg::COUNT_W-1:0] count_q [lfd_pkg::NUM_FRAMES];
  logic [lfd_pkg::SIZES_W-1:0] sizes_q [lfd_pkg::NUM_FRAMES];

  // Register writes; indexes past the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < lfd_pkg::NUM_FRAMES; f++) begin
        count_q[f] <= '0;
        sizes_q[f] <= '0;
      end
    end else if (cfg_we && (int'(cfg_index) < lfd_pkg::CFG_REGS)) begin
      for (int f = 0; f < lfd_pkg::NUM_FRAMES; f++) begin
        if (cfg_index[lfd_pkg::CFG_IDX_W-1:1] == (lfd_pkg::CFG_IDX_W-1)'(f)) begin
          if (cfg_index[0] == lfd_pkg::REG_KIND_COUNT)
            count_q[f] <= cfg_data[lfd_pkg::COUNT_W-1:0];
          if (cfg_index[0] == lfd_pkg::REG_KIND_SIZES)
            sizes_q[f] <= cfg_data[lfd_pkg::SIZES_W-1:0];
        end
      end
    end
  end

  // Layout lookup: unknown frames have no variables, counts saturate
  always_comb begin
    frame_info.count = '0;
    frame_info.sizes = '0;
    for (int f = 0; f < lfd_pkg::NUM_FRAMES; f++) begin
      if (lookup_frame == lfd_pkg::BYTE_W'(f)) begin
        frame_info.sizes = sizes_q[f];
        if (int'(count_q[f]) > lfd_pkg::MAX_VARS)
          frame_info.count = lfd_pkg::COUNT_W'(lfd_pkg::MAX_VARS);
        else
          frame_info.count = count_q[f];
      end
    end
  end

endmodule

FILE: src/lfd_parser.sv
// Byte parser: start marker, frame id, timestamp and variable assembly.
`timescale 1ns / 1ps

module lfd_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [lfd_pkg::BYTE_W-1:0]    rx_data,
  input  logic                          logging_active,
  input  lfd_pkg::frame_info_t          frame_info,
  output logic [lfd_pkg::BYTE_W-1:0]    lookup_frame,
  output lfd_pkg::result_t              result
);

  lfd_pkg::phase_t              phase, phase_next;
  logic [lfd_pkg::POS_W-1:0]    pos, pos_next;
  logic [lfd_pkg::COUNT_W-1:0]  cur_var, cur_var_next;
  logic [lfd_pkg::BYTE_W-1:0]   cur_frame, cur_frame_next;
  logic [lfd_pkg::WORD_W-1:0]   time_acc, time_acc_next;
  logic [lfd_pkg::WORD_W-1:0]   value_acc, value_acc_next;

  logic [lfd_pkg::POS_W-1:0]    size_m1;
  logic [lfd_pkg::COUNT_W:0]    var_plus1;
  logic [lfd_pkg::WORD_W-1:0]   value_base;

  assign lookup_frame = cur_frame;

  // Byte size less one of the current variable; one byte beyond the layout
  always_comb begin
    size_m1 = '0;
    if (int'(cur_var) < lfd_pkg::SIZES_W / 2)
      size_m1 = frame_info.sizes[{cur_var, 1'b0} +: lfd_pkg::POS_W];
  end

  assign var_plus1  = {1'b0, cur_var} + 1'b1;
  assign value_base = (pos == '0) ? '0 : value_acc;

  // Next state and result for the byte on the input
  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    cur_var_next   = cur_var;
    cur_frame_next = cur_frame;
    time_acc_next  = time_acc;
    value_acc_next = value_acc;
    result         = '0;

    if (!logging_active) begin
      phase_next   = lfd_pkg::PH_WAIT;
      pos_next     = '0;
      cur_var_next = '0;
    end else begin
      case (phase)
        lfd_pkg::PH_WAIT: begin
          if (rx_data == lfd_pkg::START_MARK)
            phase_next = lfd_pkg::PH_ID;
        end
        lfd_pkg::PH_ID: begin
          cur_frame_next = rx_data;
          time_acc_next  = '0;
          pos_next       = '0;
          phase_next     = lfd_pkg::PH_TIME;
        end
        lfd_pkg::PH_TIME: begin
          time_acc_next = {time_acc[lfd_pkg::WORD_W-lfd_pkg::BYTE_W-1:0], rx_data};
          if (pos != lfd_pkg::TIME_LAST_POS) begin
            pos_next = pos + 1'b1;
          end else begin
            pos_next     = '0;
            cur_var_next = '0;
            if (frame_info.count == '0) begin
              // frame without variables ends at its timestamp
              phase_next          = lfd_pkg::PH_ID;
              result.emit         = 1'b1;
              result.kind         = 1'b1;
              result.frame_last   = 1'b1;
            end else begin
              phase_next = lfd_pkg::PH_VARS;
            end
          end
        end
        lfd_pkg::PH_VARS: begin
          value_acc_next = {value_base[lfd_pkg::WORD_W-lfd_pkg::BYTE_W-1:0], rx_data};
          if (pos < size_m1) begin
            pos_next = pos + 1'b1;
          end else begin
            pos_next         = '0;
            result.emit      = 1'b1;
            result.var_index = cur_var;
            result.var_value = value_acc_next;
            if (var_plus1 >= {1'b0, frame_info.count}) begin
              result.frame_last = 1'b1;
              phase_next        = lfd_pkg::PH_ID;
              cur_var_next      = '0;
            end else begin
              cur_var_next = var_plus1[lfd_pkg::COUNT_W-1:0];
            end
          end
        end
        default: begin
          phase_next = lfd_pkg::PH_WAIT;
        end
      endcase
    end

    result.frame_number = cur_frame_next;
    result.frame_time   = time_acc_next;
  end

  // State update on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= lfd_pkg::PH_WAIT;
      pos       <= '0;
      cur_var   <= '0;
      cur_frame <= '0;
      time_acc  <= '0;
      value_acc <= '0;
    end else if (step) begin
      phase     <= phase_next;
      pos       <= pos_next;
      cur_var   <= cur_var_next;
      cur_frame <= cur_frame_next;
      time_acc  <= time_acc_next;
      value_acc <= value_acc_next;
    end
  end

  // An empty-frame result always closes the frame with zero index and value
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    (result.emit && result.kind) |->
      (result.frame_last && (result.var_index == '0) && (result.var_value == '0)))
    else $error("empty-frame result malformed");

  // Dropping logging returns the parser to waiting with counters cleared
  a_inactive: assert property (@(posedge clk) disable iff (rst)
    (step && !logging_active) |=>
      ((phase == lfd_pkg::PH_WAIT) && (pos == '0) && (cur_var == '0)))
    else $error("parser not cleared after logging stopped");

  // Between frames the byte and variable counters are idle
  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    ((phase == lfd_pkg::PH_WAIT) || (phase == lfd_pkg::PH_ID)) |->
      ((pos == '0) && (cur_var == '0)))
    else $error("counters not idle between frames");

  // Variable number stays inside the layout
  a_var_range: assert property (@(posedge clk) disable iff (rst)
    (phase == lfd_pkg::PH_VARS) |-> (int'(cur_var) < lfd_pkg::MAX_VARS))
    else $error("variable number out of range");

endmodule

FILE: dv/log_frame_deserializer_tb.sv
// Self-checking testbench for the log frame deserializer: directed script, then random frames.
`timescale 1ns / 1ps

module log_frame_deserializer_tb;
  import lfd_pkg::*;

  // Run shape
  localparam int RANDOM_ITEMS = 1400;
  localparam int PHASE_ITEMS  = 150;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 4;
  localparam int REPORT_LIMIT = 10;

  // Register indexes used by the directed script
  localparam logic [CFG_IDX_W-1:0] REG_F0_COUNT = {2'd0, REG_KIND_COUNT};
  localparam logic [CFG_IDX_W-1:0] REG_F0_SIZES = {2'd0, REG_KIND_SIZES};
  localparam logic [CFG_IDX_W-1:0] REG_F1_COUNT = {2'd1, REG_KIND_COUNT};
  localparam logic [CFG_IDX_W-1:0] REG_F1_SIZES = {2'd1, REG_KIND_SIZES};
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(CFG_REGS);

  // Result kinds
  localparam logic KIND_VAR   = 1'b0;
  localparam logic KIND_EMPTY = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [BYTE_W-1:0]  frame_number;
    logic [WORD_W-1:0]  frame_time;
    logic [COUNT_W-1:0] var_index;
    logic [WORD_W-1:0]  var_value;
    logic               frame_last;
  } log_rec_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              active;
    bit                typed;
    log_rec_t          want;
  } rx_byte_t;

  typedef struct packed {
    bit                     is_reg;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    rx_byte_t               item;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     rx_data = '0;
  logic                  logging_active = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  kind;
  logic [BYTE_W-1:0]     frame_number;
  logic [WORD_W-1:0]     frame_time;
  logic [COUNT_W-1:0]    var_index;
  logic [WORD_W-1:0]     var_value;
  logic                  frame_last;

  log_frame_deserializer i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_data        (rx_data),
    .logging_active (logging_active),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .frame_number   (frame_number),
    .frame_time     (frame_time),
    .var_index      (var_index),
    .var_value      (var_value),
    .frame_last     (frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Layout copy and parser state of the predictor
  logic [COUNT_W-1:0] lay_count [NUM_FRAMES] = '{default: '0};
  logic [SIZES_W-1:0] lay_sizes [NUM_FRAMES] = '{default: '0};
  phase_t             ph = PH_WAIT;
  logic [POS_W-1:0]   pos = '0;
  logic [COUNT_W-1:0] var_no = '0;
  logic [BYTE_W-1:0]  frame_byte = '0;
  logic [WORD_W-1:0]  stamp = '0;
  logic [WORD_W-1:0]  acc_value = '0;

  rx_byte_t    rx_backlog [$];
  log_rec_t    pending_records [$];
  script_row_t script [$];
  rx_byte_t    on_wire = '0;
  int unsigned pushed_n = 0;
  int unsigned accepted_n = 0;
  int unsigned bad_results = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_arm = 1'b0;
  bit          hold_used = 1'b0;

  function automatic log_rec_t make_rec(input logic k, input logic [BYTE_W-1:0] fr,
                                        input logic [WORD_W-1:0] t,
                                        input logic [COUNT_W-1:0] idx,
                                        input logic [WORD_W-1:0] v, input logic last);
    log_rec_t r;
    r.kind         = k;
    r.frame_number = fr;
    r.frame_time   = t;
    r.var_index    = idx;
    r.var_value    = v;
    r.frame_last   = last;
    return r;
  endfunction

  // Variables in a frame; unknown ids have none, counts saturate
  function automatic int unsigned vars_in(input logic [BYTE_W-1:0] f);
    int unsigned c;
    if (int'(f) >= NUM_FRAMES) return 0;
    c = int'(lay_count[f[1:0]]);
    if (c > MAX_VARS) c = MAX_VARS;
    return c;
  endfunction

  function automatic int unsigned var_bytes(input logic [BYTE_W-1:0] f, input int unsigned v);
    if (int'(f) >= NUM_FRAMES || v > MAX_VARS - 1) return 1;
    return int'(lay_sizes[f[1:0]][6'(2 * v) +: 2]) + 1;
  endfunction

  // Advance the frame parser by one byte; returns 1 when a record completes
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic act,
                                     output log_rec_t rec);
    int unsigned n;
    int unsigned sz;
    bit          ends;
    rec = '0;
    if (!act) begin
      ph     = PH_WAIT;
      pos    = '0;
      var_no = '0;
      return 1'b0;
    end
    case (ph)
      PH_WAIT: begin
        if (b == START_MARK) ph = PH_ID;
      end
      PH_ID: begin
        frame_byte = b;
        stamp      = '0;
        pos        = '0;
        ph         = PH_TIME;
      end
      PH_TIME: begin
        stamp = {stamp[WORD_W-BYTE_W-1:0], b};
        if (pos < TIME_LAST_POS) begin
          pos++;
        end else begin
          pos    = '0;
          var_no = '0;
          if (vars_in(frame_byte) == 0) begin
            ph  = PH_ID;
            rec = make_rec(KIND_EMPTY, frame_byte, stamp, '0, '0, 1'b1);
            return 1'b1;
          end
          ph = PH_VARS;
        end
      end
      default: begin
        // layout is read afresh on every byte
        n  = vars_in(frame_byte);
        sz = var_bytes(frame_byte, int'(var_no));
        if (pos == '0) acc_value = '0;
        acc_value = {acc_value[WORD_W-BYTE_W-1:0], b};
        if (int'(pos) + 1 < sz) begin
          pos++;
        end else begin
          pos  = '0;
          ends = (int'(var_no) + 1 >= n);
          rec  = make_rec(KIND_VAR, frame_byte, stamp, var_no, acc_value, ends);
          if (ends) begin
            ph     = PH_ID;
            var_no = '0;
          end else begin
            var_no++;
          end
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void queue_byte(input logic [BYTE_W-1:0] d, input logic a,
                                     input bit typed = 1'b0, input log_rec_t want = '0);
    rx_byte_t it;
    it.data   = d;
    it.active = a;
    it.typed  = typed;
    it.want   = want;
    rx_backlog.insert(rx_backlog.size(), it);
    pushed_n++;
  endfunction

  function automatic void add_row(input script_row_t s);
    script.insert(script.size(), s);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] wide_rand();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[CFG_DATA_W-1:0];
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (int'(idx) < CFG_REGS) begin
      if (idx[0] == REG_KIND_COUNT) lay_count[idx[CFG_IDX_W-1:1]] = val[COUNT_W-1:0];
      else lay_sizes[idx[CFG_IDX_W-1:1]] = val[SIZES_W-1:0];
    end
  endtask

  // Wait for every byte to transfer and every record to arrive, then let the pipe empty
  task automatic settle();
    while (accepted_n != pushed_n || pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Fresh layout for all frames: empty, single, full, saturating and small counts
  task automatic new_layout();
    logic [CFG_DATA_W-1:0] v;
    logic [COUNT_W-1:0]    c;
    for (int f = 0; f < NUM_FRAMES; f++) begin
      case ($urandom_range(9))
        0: c = '0;
        1: c = COUNT_W'(1);
        2: c = COUNT_W'(MAX_VARS);
        3: c = COUNT_W'($urandom_range(31, MAX_VARS + 1));
        default: c = COUNT_W'($urandom_range(6, 1));
      endcase
      v = wide_rand();
      v[COUNT_W-1:0] = c;
      write_reg({f[1:0], REG_KIND_COUNT}, v);
      case ($urandom_range(5))
        0: v = '0;
        1: v = '1;
        default: v = wide_rand();
      endcase
      write_reg({f[1:0], REG_KIND_SIZES}, v);
    end
    if ($urandom_range(2) == 0)
      write_reg(CFG_IDX_W'(CFG_REGS + $urandom_range(1)), wide_rand());
  endtask

  // Mostly well-formed marker+frame bursts with random content, some noise and cut frames
  function automatic int unsigned fill_phase(input bit resync);
    int unsigned live;
    int unsigned len;
    int unsigned cut;
    int unsigned r;
    logic [BYTE_W-1:0] id;
    bit broken;
    live = 0;
    while (live < PHASE_ITEMS) begin
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(6, 1)) begin
          queue_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(3) != 0));
          live++;
        end
      end else begin
        if (resync || $urandom_range(99) < 15) queue_byte(BYTE_W'($urandom_range(255)), 1'b0);
        resync = 1'b0;
        queue_byte(START_MARK, 1'b1);
        live++;
        broken = 1'b0;
        for (int fr = $urandom_range(3, 1); fr > 0 && !broken; fr--) begin
          r = $urandom_range(9);
          if (r < 7) id = BYTE_W'($urandom_range(NUM_FRAMES - 1));
          else if (r == 7) id = START_MARK;
          else id = BYTE_W'($urandom_range(255, NUM_FRAMES));
          len = 5;
          for (int v = 0; v < int'(vars_in(id)); v++) len += var_bytes(id, v);
          cut = ($urandom_range(99) < 5) ? $urandom_range(len - 1, 1) : len;
          queue_byte(id, 1'b1);
          for (int k = 1; k < int'(cut); k++) queue_byte(BYTE_W'($urandom_range(255)), 1'b1);
          live += cut;
          if (cut < len) begin
            // logging drops out mid-frame
            queue_byte(BYTE_W'($urandom_range(255)), 1'b0);
            broken = 1'b1;
          end
        end
      end
    end
    return live;
  endfunction

  // Sender: present bytes, predict each transfer as it happens
  always @(posedge clk) begin : feed
    log_rec_t pred;
    bit       hit;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hit = decode_byte(on_wire.data, on_wire.active, pred);
        if (on_wire.typed) pending_records.insert(pending_records.size(), on_wire.want);
        else if (hit) pending_records.insert(pending_records.size(), pred);
        accepted_n++;
      end
      if (!in_valid || in_ready) begin
        if (rx_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          on_wire = rx_backlog.pop_front();
          in_valid       <= 1'b1;
          rx_data        <= on_wire.data;
          logging_active <= on_wire.active;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off so the output register fills and input stalls
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_used) begin
      hold_left <= LONG_HOLD;
      hold_used <= 1'b1;
    end
  end

  // Receiver
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  // Compare each record transfer with the oldest prediction
  always @(posedge clk) begin : check
    log_rec_t seen;
    log_rec_t want;
    if (!rst && out_valid && out_ready) begin
      seen = make_rec(kind, frame_number, frame_time, var_index, var_value, frame_last);
      if (pending_records.size() == 0) begin
        if (bad_results < REPORT_LIMIT)
          $display("%0t unexpected record: kind=%0d frame=%0d time=%08h idx=%0d val=%08h last=%0d",
                   $time, seen.kind, seen.frame_number, seen.frame_time, seen.var_index,
                   seen.var_value, seen.frame_last);
        bad_results++;
      end else begin
        want = pending_records.pop_front();
        if (seen !== want) begin
          if (bad_results < REPORT_LIMIT) begin
            $display("%0t record mismatch", $time);
            $display("  want kind=%0d frame=%0d time=%08h idx=%0d val=%08h last=%0d",
                     want.kind, want.frame_number, want.frame_time, want.var_index,
                     want.var_value, want.frame_last);
            $display("  got  kind=%0d frame=%0d time=%08h idx=%0d val=%08h last=%0d",
                     seen.kind, seen.frame_number, seen.frame_time, seen.var_index,
                     seen.var_value, seen.frame_last);
          end
          bad_results++;
        end
      end
    end
  end

  function automatic script_row_t dir_byte(input logic [BYTE_W-1:0] d, input logic a);
    script_row_t s;
    s = '0;
    s.item.data   = d;
    s.item.active = a;
    return s;
  endfunction

  function automatic script_row_t dir_check(input logic [BYTE_W-1:0] d, input log_rec_t w);
    script_row_t s;
    s = dir_byte(d, 1'b1);
    s.item.typed = 1'b1;
    s.item.want  = w;
    return s;
  endfunction

  function automatic script_row_t dir_reg(input logic [CFG_IDX_W-1:0] i,
                                          input logic [CFG_DATA_W-1:0] v);
    script_row_t s;
    s = '0;
    s.is_reg  = 1'b1;
    s.reg_idx = i;
    s.reg_val = v;
    return s;
  endfunction

  initial begin : run
    int unsigned live;
    int          phase_no;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty frame with reset layout
    add_row(dir_byte(START_MARK, 1'b1));
    add_row(dir_byte(8'h00, 1'b1));
    repeat (3) add_row(dir_byte(8'h00, 1'b1));
    add_row(dir_check(8'h00, make_rec(KIND_EMPTY, 8'h00, '0, '0, '0, 1'b1)));
    // logging off, then a stray byte while waiting for the marker
    add_row(dir_byte(8'hA5, 1'b0));
    add_row(dir_byte(8'h00, 1'b1));
    // unknown frame id at the top of the range, all-ones timestamp
    add_row(dir_byte(START_MARK, 1'b1));
    add_row(dir_byte(8'hFF, 1'b1));
    repeat (3) add_row(dir_byte(8'hFF, 1'b1));
    add_row(dir_check(8'hFF, make_rec(KIND_EMPTY, 8'hFF, '1, '0, '0, 1'b1)));
    // saturating count on frame zero, two-variable layout on frame one, unmapped write
    add_row(dir_reg(REG_F0_COUNT, '1));
    add_row(dir_reg(REG_F0_SIZES, '1));
    add_row(dir_reg(REG_F1_COUNT, 48'hA5A5_0000_0002));
    add_row(dir_reg(REG_F1_SIZES, 48'h0000_0000_000C));
    add_row(dir_reg(REG_UNMAPPED, '1));
    // frame one: one-byte then four-byte variable
    add_row(dir_byte(8'h01, 1'b1));
    add_row(dir_byte(8'h80, 1'b1));
    add_row(dir_byte(8'h00, 1'b1));
    add_row(dir_byte(8'h00, 1'b1));
    add_row(dir_byte(8'h01, 1'b1));
    add_row(dir_check(8'hFF, make_rec(KIND_VAR, 8'h01, 32'h8000_0001, '0, 32'hFF, 1'b0)));
    add_row(dir_byte(8'hDE, 1'b1));
    add_row(dir_byte(8'hAD, 1'b1));
    add_row(dir_byte(8'hBE, 1'b1));
    add_row(dir_check(8'hEF, make_rec(KIND_VAR, 8'h01, 32'h8000_0001, 5'd1,
                                      32'hDEAD_BEEF, 1'b1)));
    add_row(dir_byte(8'h00, 1'b0));

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        settle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        queue_byte(script[i].item.data, script[i].item.active, script[i].item.typed,
                   script[i].item.want);
      end
    end
    settle();

    // Random phases, each with its own layout and pacing; parser state carries over
    live     = 0;
    phase_no = 0;
    while (live < RANDOM_ITEMS) begin
      case (phase_no % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      new_layout();
      live += fill_phase(phase_no % 2 == 0);
      if (phase_no == 0) hold_arm <= 1'b1;
      settle();
      phase_no++;
    end

    if (bad_results == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
